@@ hdl/rsnh_pkg.sv @@
// Shared types, widths and codes for the ray segment nearest hit block.
`default_nettype none

package rsnh_pkg;

    // Field widths.
    localparam int COORD_BITS      = 24;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int T_BITS          = 24;

    // Derived datapath widths: differences, products, cross products, scaled numerator, divider step count.
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int NUM_W   = CROSS_W + PARAM_FRAC_BITS;
    localparam int CNT_W   = $clog2(T_BITS);

    // Item mode codes.
    localparam logic MODE_BEGIN   = 1'b0;
    localparam logic MODE_SEGMENT = 1'b1;

    // Input word.
    typedef struct packed {
        logic                          mode;
        logic signed [COORD_BITS-1:0]  first_x;
        logic signed [COORD_BITS-1:0]  first_y;
        logic signed [COORD_BITS-1:0]  second_x;
        logic signed [COORD_BITS-1:0]  second_y;
        logic                          world_check;
        logic                          last;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic                          hit;
        logic        [T_BITS-1:0]      hit_t;
        logic signed [COORD_BITS-1:0]  hit_start_x;
        logic signed [COORD_BITS-1:0]  hit_start_y;
        logic signed [COORD_BITS-1:0]  hit_end_x;
        logic signed [COORD_BITS-1:0]  hit_end_y;
    } out_word_t;

    // Multiply steps: each cross product is a load of one product and a subtract of another.
    typedef enum logic [2:0] {
        MS_DEN_A = 3'd0,   // den  = ry*sx
        MS_DEN_B = 3'd1,   // den -= rx*sy
        MS_TN_A  = 3'd2,   // tn   = wy*sx
        MS_TN_B  = 3'd3,   // tn  -= wx*sy
        MS_UN_A  = 3'd4,   // un   = wy*rx
        MS_UN_B  = 3'd5    // un  -= wx*ry
    } mul_step_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        logic      mul_en;
        mul_step_t mul_step;
        logic      div_init;
        logic      div_sat;
        logic      div_step;
        logic      update_best;
        logic      emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tests_enabled;
        logic seg_ok;
        logic div_sat;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ hdl/rsnh_dp.sv @@
// Datapath: ray and segment registers, shared multiplier, cross products, divider, best hit.
`default_nettype none

module rsnh_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rsnh_pkg::in_word_t  s_data,
    input  wire rsnh_pkg::dp_cmd_t   cmd,
    output rsnh_pkg::dp_sts_t        sts,
    output rsnh_pkg::out_word_t      m_data
);

    localparam int CW  = rsnh_pkg::COORD_BITS;
    localparam int DW  = rsnh_pkg::DIFF_W;
    localparam int PW  = rsnh_pkg::PROD_W;
    localparam int XW  = rsnh_pkg::CROSS_W;
    localparam int NW  = rsnh_pkg::NUM_W;
    localparam int TB  = rsnh_pkg::T_BITS;
    localparam int PFB = rsnh_pkg::PARAM_FRAC_BITS;

    // Ray state.
    logic signed [CW-1:0] ray_from_x_reg, ray_from_y_reg;
    logic signed [DW-1:0] rx_reg, ry_reg;
    logic                 tests_enabled_reg;

    // Current segment and its differences.
    logic signed [CW-1:0] seg_c_x_reg, seg_c_y_reg, seg_d_x_reg, seg_d_y_reg;
    logic signed [DW-1:0] sx_reg, sy_reg, wx_reg, wy_reg;

    // Multiplier pipeline and cross product accumulators.
    logic signed [PW-1:0] prod_reg;
    logic                 prod_valid_reg;
    rsnh_pkg::mul_step_t  prod_step_reg;
    logic signed [DW-1:0] op_a, op_b;
    logic signed [PW-1:0] mul_out;
    logic signed [XW-1:0] prod_ext;
    logic signed [XW-1:0] den_reg, tn_reg, un_reg;

    // Divider.
    logic [XW-1:0] rem_reg;
    logic [TB-1:0] lo_reg;
    logic [TB-1:0] quot_reg;
    logic [NW-1:0] num_scaled;
    logic [XW-1:0] den_u;
    logic [XW:0]   cand;
    logic [XW:0]   cand_diff;
    logic          cand_ge;

    // Best hit record.
    logic                 best_found_reg;
    logic [TB-1:0]        best_t_reg;
    logic signed [CW-1:0] best_c_x_reg, best_c_y_reg, best_d_x_reg, best_d_y_reg;

    rsnh_pkg::out_word_t m_data_reg;

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = ry_reg;
        op_b = sx_reg;
        unique case (cmd.mul_step)
            rsnh_pkg::MS_DEN_A: begin op_a = ry_reg; op_b = sx_reg; end
            rsnh_pkg::MS_DEN_B: begin op_a = rx_reg; op_b = sy_reg; end
            rsnh_pkg::MS_TN_A:  begin op_a = wy_reg; op_b = sx_reg; end
            rsnh_pkg::MS_TN_B:  begin op_a = wx_reg; op_b = sy_reg; end
            rsnh_pkg::MS_UN_A:  begin op_a = wy_reg; op_b = rx_reg; end
            rsnh_pkg::MS_UN_B:  begin op_a = wx_reg; op_b = ry_reg; end
            default:            begin op_a = ry_reg; op_b = sx_reg; end
        endcase
    end

    assign mul_out  = PW'(op_a) * PW'(op_b);
    assign prod_ext = XW'(prod_reg);

    // Segment test: the denominator must be positive, t must not be negative and u must lie in [0, 1].
    assign sts.tests_enabled = tests_enabled_reg;
    assign sts.seg_ok = !den_reg[XW-1] && (den_reg != '0) && !tn_reg[XW-1]
                        && !un_reg[XW-1] && (un_reg <= den_reg);

    // Divider: the top part of the scaled numerator seeds the remainder.
    assign num_scaled = {tn_reg, {PFB{1'b0}}};
    assign den_u      = den_reg;
    assign sts.div_sat = (rem_reg >= den_u);
    assign cand       = {rem_reg, lo_reg[TB-1]};
    assign cand_diff  = cand - {1'b0, den_u};
    assign cand_ge    = (cand >= {1'b0, den_u});

    assign m_data = m_data_reg;

    // Ray registers and the best hit record carry reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ray_from_x_reg    <= '0;
            ray_from_y_reg    <= '0;
            rx_reg            <= '0;
            ry_reg            <= '0;
            tests_enabled_reg <= 1'b0;
            best_found_reg    <= 1'b0;
            best_t_reg        <= '1;
            best_c_x_reg      <= '0;
            best_c_y_reg      <= '0;
            best_d_x_reg      <= '0;
            best_d_y_reg      <= '0;
            prod_valid_reg    <= 1'b0;
        end else begin
            prod_valid_reg <= cmd.mul_en;
            if (cmd.load_item && s_data.mode == rsnh_pkg::MODE_BEGIN) begin
                ray_from_x_reg    <= s_data.first_x;
                ray_from_y_reg    <= s_data.first_y;
                rx_reg            <= DW'(s_data.second_x) - DW'(s_data.first_x);
                ry_reg            <= DW'(s_data.second_y) - DW'(s_data.first_y);
                tests_enabled_reg <= s_data.world_check;
            end
            if ((cmd.load_item && s_data.mode == rsnh_pkg::MODE_BEGIN) || cmd.emit) begin
                best_found_reg <= 1'b0;
                best_t_reg     <= '1;
                best_c_x_reg   <= '0;
                best_c_y_reg   <= '0;
                best_d_x_reg   <= '0;
                best_d_y_reg   <= '0;
            end else if (cmd.update_best && (!best_found_reg || quot_reg < best_t_reg)) begin
                best_found_reg <= 1'b1;
                best_t_reg     <= quot_reg;
                best_c_x_reg   <= seg_c_x_reg;
                best_c_y_reg   <= seg_c_y_reg;
                best_d_x_reg   <= seg_d_x_reg;
                best_d_y_reg   <= seg_d_y_reg;
            end
        end
    end

    // Segment capture, product accumulation, division and result word.
    always_ff @(posedge aclk) begin
        if (cmd.load_item && s_data.mode == rsnh_pkg::MODE_SEGMENT) begin
            seg_c_x_reg <= s_data.first_x;
            seg_c_y_reg <= s_data.first_y;
            seg_d_x_reg <= s_data.second_x;
            seg_d_y_reg <= s_data.second_y;
            sx_reg      <= DW'(s_data.second_x) - DW'(s_data.first_x);
            sy_reg      <= DW'(s_data.second_y) - DW'(s_data.first_y);
            wx_reg      <= DW'(s_data.first_x) - DW'(ray_from_x_reg);
            wy_reg      <= DW'(s_data.first_y) - DW'(ray_from_y_reg);
        end

        if (cmd.mul_en) begin
            prod_reg      <= mul_out;
            prod_step_reg <= cmd.mul_step;
        end

        if (prod_valid_reg) begin
            unique case (prod_step_reg)
                rsnh_pkg::MS_DEN_A: den_reg <= prod_ext;
                rsnh_pkg::MS_DEN_B: den_reg <= den_reg - prod_ext;
                rsnh_pkg::MS_TN_A:  tn_reg  <= prod_ext;
                rsnh_pkg::MS_TN_B:  tn_reg  <= tn_reg - prod_ext;
                rsnh_pkg::MS_UN_A:  un_reg  <= prod_ext;
                rsnh_pkg::MS_UN_B:  un_reg  <= un_reg - prod_ext;
                default:            un_reg  <= un_reg;
            endcase
        end

        if (cmd.div_init) begin
            rem_reg  <= XW'(num_scaled[NW-1:TB]);
            lo_reg   <= num_scaled[TB-1:0];
            quot_reg <= '0;
        end else if (cmd.div_sat) begin
            quot_reg <= '1;
        end else if (cmd.div_step) begin
            rem_reg  <= cand_ge ? cand_diff[XW-1:0] : cand[XW-1:0];
            lo_reg   <= {lo_reg[TB-2:0], 1'b0};
            quot_reg <= {quot_reg[TB-2:0], cand_ge};
        end

        if (cmd.emit) begin
            m_data_reg.hit         <= best_found_reg;
            m_data_reg.hit_t       <= best_t_reg;
            m_data_reg.hit_start_x <= best_c_x_reg;
            m_data_reg.hit_start_y <= best_c_y_reg;
            m_data_reg.hit_end_x   <= best_d_x_reg;
            m_data_reg.hit_end_y   <= best_d_y_reg;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rsnh_ctrl.sv @@
// Controller: sequences multiply steps, the divider, the best hit update and result output.
`default_nettype none

module rsnh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_mode,
    input  wire logic              s_last,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rsnh_pkg::dp_cmd_t      cmd,
    input  wire rsnh_pkg::dp_sts_t sts
);

    localparam int CNT_W = rsnh_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_CHECK,
        ST_SATCHK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    rsnh_pkg::mul_step_t mstep_reg, mstep_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                last_reg, last_next;
    logic                out_full_reg, out_full_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_full_reg;

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        mstep_next    = mstep_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        cmd           = '0;
        cmd.mul_step  = mstep_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    last_next     = s_last;
                    mstep_next    = rsnh_pkg::MS_DEN_A;
                    if (s_mode == rsnh_pkg::MODE_SEGMENT && sts.tests_enabled) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                unique case (mstep_reg)
                    rsnh_pkg::MS_DEN_A: mstep_next = rsnh_pkg::MS_DEN_B;
                    rsnh_pkg::MS_DEN_B: mstep_next = rsnh_pkg::MS_TN_A;
                    rsnh_pkg::MS_TN_A:  mstep_next = rsnh_pkg::MS_TN_B;
                    rsnh_pkg::MS_TN_B:  mstep_next = rsnh_pkg::MS_UN_A;
                    rsnh_pkg::MS_UN_A:  mstep_next = rsnh_pkg::MS_UN_B;
                    default:            state_next = ST_DRAIN;
                endcase
            end
            ST_DRAIN: begin
                // The last product is accumulated in this cycle.
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.seg_ok) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_SATCHK;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SATCHK: begin
                count_next = '0;
                if (sts.div_sat) begin
                    cmd.div_sat = 1'b1;
                    state_next  = ST_UPDATE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (count_reg == CNT_W'(rsnh_pkg::T_BITS - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update_best = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!out_full_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output word holding flag.
    always_comb begin
        out_full_next = out_full_reg;
        if (cmd.emit) begin
            out_full_next = 1'b1;
        end else if (m_ready) begin
            out_full_next = 1'b0;
        end
    end

    // State and registered control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mstep_reg    <= rsnh_pkg::MS_DEN_A;
            count_reg    <= '0;
            last_reg     <= 1'b0;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mstep_reg    <= mstep_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            out_full_reg <= out_full_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ray_segment_nearest_hit_top.sv @@
// Top level of the ray segment nearest hit block: controller plus datapath.
//
// Channel | Ports                      | Word
// --------+----------------------------+-----------------------------------------
// input   | s_valid, s_ready, s_data   | mode, ray or segment end points, flags
// result  | m_valid, m_ready, m_data   | hit, nearest t, winning segment
//
// A begin item, or a segment when tests are off, goes straight to the finish state.
// A tested segment makes six passes through the one 25x25 multiplier and is checked;
// a hit then saturates or runs a restoring divider that makes one quotient bit a cycle.
// Reset is synchronous and active low; it clears the ray and the best hit record.
// A finished result waits in an output register; a stalled result channel holds only
// an item with last set, in its final cycle.
`default_nettype none

module ray_segment_nearest_hit_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rsnh_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rsnh_pkg::out_word_t      m_data
);

    rsnh_pkg::dp_cmd_t cmd;
    rsnh_pkg::dp_sts_t sts;

    // Sequencing.
    rsnh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_data.mode),
        .s_last  (s_data.last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Arithmetic and storage.
    rsnh_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
